@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the rtl checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define SWTFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SWTFS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/swtfs_pkg.sv @@
// ----------------------------------------------------------------------------
// swtfs_pkg
// types and register codes of the sliding window top frequency sum block
// ----------------------------------------------------------------------------
package swtfs_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int SUM_W     = 40;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [CFG_W-1:0]           t_cfg;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx REG_WINDOW_LEN = t_cfg_idx'(0);
    localparam t_cfg_idx REG_TOP_COUNT  = t_cfg_idx'(1);

endpackage

@@ rtl/swtfs_ram.sv @@
// ----------------------------------------------------------------------------
// swtfs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swtfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sliding_window_top_frequency_sum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_top_frequency_sum
// window of recent samples with a count table, sums count times value over
// the top ranked distinct values with one shared compare and multiply unit
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      i_in_valid/o_in_stall  i_sample, i_start_req
// out       output     o_out_valid/i_out_stall o_window_sum
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction: an eviction scan (only when the window is full) and an
// insert scan over the count table plus control states, then, when the
// window is full, one ranking scan plus a multiply and an accumulate step
// per summed value, repeated min(top_count, distinct + 1) times;
// the single read port of the count table sets the scan pace.
// reset, a window_len write and start_req run a clearing pass over the
// count table, the in channel is stalled meanwhile.
// a finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module sliding_window_top_frequency_sum #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swtfs_pkg::t_sample   i_sample,
    input  logic                 i_start_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swtfs_pkg::t_sum      o_window_sum,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  swtfs_pkg::t_cfg_idx  i_cfg_index,
    input  swtfs_pkg::t_cfg      i_cfg_data
);
    import swtfs_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EVICT_CHK, S_EVICT_RD, S_PUSH,
        S_SCAN, S_FINISH, S_MUL, S_ACC, S_DONE
    } t_state;

    typedef enum logic [1:0] {M_REMOVE, M_ADD, M_MAX} t_mode;

    t_state          r_state;
    t_mode           r_mode;
    t_cfg            r_wlen;
    t_cfg            r_top;
    t_cfg            r_taken;
    logic [CW-1:0]   r_fill;
    logic [AW-1:0]   r_oldest;
    t_sample         r_sample;
    t_sample         r_key;
    logic            r_pending;
    logic [AW:0]     r_addr;
    logic            r_rv;
    logic [AW-1:0]   r_ri;
    logic [AW-1:0]   r_free;
    logic            r_free_ok;
    logic [CW-1:0]   r_bc;
    t_sample         r_bv;
    logic            r_bok;
    logic [CW-1:0]   r_pc;
    t_sample         r_pv;
    logic            r_pok;
    t_sum            r_prod;
    t_sum            r_acc;
    logic            r_ov;
    t_sum            r_sum;

    t_sample         win_rdata;
    t_sample         val_rdata;
    logic [CW-1:0]   cnt_rdata;

    logic            cnt_we;
    logic [AW-1:0]   cnt_waddr;
    logic [CW-1:0]   cnt_wdata;
    logic            val_we;

    logic [CW-1:0]   eff_len;
    logic            cfg_wr;
    logic            in_acc;
    logic            live;
    logic            hit;
    logic            last;
    logic            above_best;
    logic            below_prev;
    logic            cand;
    logic [AW-1:0]   n_free;
    logic            n_free_ok;
    logic [AW+1:0]   pos_sum;
    logic [AW-1:0]   push_pos;
    logic [AW-1:0]   oldest_inc;
    logic signed [63:0] prod64;
    logic            out_free;

    always_comb begin
        if (r_wlen == '0) begin
            eff_len = CW'(1);
        end else if (32'(r_wlen) > 32'(WINDOW_MAX)) begin
            eff_len = CW'(WINDOW_MAX);
        end else begin
            eff_len = CW'(r_wlen);
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign live = r_rv && (cnt_rdata != '0);
    assign hit  = live && (val_rdata == r_key);
    assign last = r_rv && (r_ri == AW'(WINDOW_MAX - 1));

    // ranking key is (count, value), compared lexicographically
    assign above_best = !r_bok || (cnt_rdata > r_bc) ||
                        ((cnt_rdata == r_bc) && (val_rdata > r_bv));
    assign below_prev = !r_pok || (cnt_rdata < r_pc) ||
                        ((cnt_rdata == r_pc) && (val_rdata < r_pv));
    assign cand = (r_mode == M_MAX) && live && above_best && below_prev;

    always_comb begin
        n_free    = r_free;
        n_free_ok = r_free_ok;
        if (!r_free_ok && r_rv && (cnt_rdata == '0)) begin
            n_free    = r_ri;
            n_free_ok = 1'b1;
        end
    end

    assign pos_sum  = (AW+2)'(r_oldest) + (AW+2)'(r_fill);
    assign push_pos = (pos_sum >= (AW+2)'(WINDOW_MAX)) ?
                      AW'(pos_sum - (AW+2)'(WINDOW_MAX)) : AW'(pos_sum);
    assign oldest_inc = (r_oldest == AW'(WINDOW_MAX - 1)) ? '0 : r_oldest + AW'(1);

    assign prod64   = 64'(signed'({1'b0, r_bc}) * r_bv);
    assign out_free = !r_ov || !i_out_stall;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_ri;
        cnt_wdata = '0;
        val_we    = 1'b0;
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_addr[AW-1:0];
        end else if (r_state == S_SCAN && r_mode == M_REMOVE && hit) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata - CW'(1);
        end else if (r_state == S_SCAN && r_mode == M_ADD && hit) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata + CW'(1);
        end else if (r_state == S_SCAN && r_mode == M_ADD && last && n_free_ok) begin
            // value not present, install it in the first free slot
            cnt_we    = 1'b1;
            cnt_waddr = n_free;
            cnt_wdata = CW'(1);
            val_we    = 1'b1;
        end
    end

    swtfs_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUSH),
        .i_waddr (push_pos),
        .i_wdata (r_sample),
        .i_raddr (r_oldest),
        .o_rdata (win_rdata)
    );

    swtfs_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (n_free),
        .i_wdata (r_key),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (val_rdata)
    );

    swtfs_ram #(.WIDTH(CW), .DEPTH(WINDOW_MAX)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_mode    <= M_REMOVE;
            r_wlen    <= CFG_W'(1);
            r_top     <= CFG_W'(1);
            r_fill    <= '0;
            r_oldest  <= '0;
            r_pending <= 1'b0;
            r_addr    <= '0;
            r_rv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + (AW+1)'(1);
                    if (r_addr[AW-1:0] == AW'(WINDOW_MAX - 1)) begin
                        r_state <= r_pending ? S_EVICT_CHK : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cfg_wr) begin
                        if (i_cfg_index == REG_WINDOW_LEN) begin
                            r_wlen    <= i_cfg_data;
                            r_fill    <= '0;
                            r_oldest  <= '0;
                            r_addr    <= '0;
                            r_pending <= 1'b0;
                            r_state   <= S_CLEAR;
                        end else if (i_cfg_index == REG_TOP_COUNT) begin
                            r_top <= i_cfg_data;
                        end
                    end else if (in_acc) begin
                        r_sample <= i_sample;
                        if (i_start_req) begin
                            r_fill    <= '0;
                            r_oldest  <= '0;
                            r_addr    <= '0;
                            r_pending <= 1'b1;
                            r_state   <= S_CLEAR;
                        end else begin
                            r_state <= S_EVICT_CHK;
                        end
                    end
                end
                S_EVICT_CHK: begin
                    // window ram reads the oldest slot during this cycle
                    if (r_fill >= eff_len && r_fill != '0) begin
                        r_state <= S_EVICT_RD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_EVICT_RD: begin
                    r_key     <= win_rdata;
                    r_mode    <= M_REMOVE;
                    r_addr    <= '0;
                    r_rv      <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_PUSH: begin
                    r_fill    <= r_fill + CW'(1);
                    r_key     <= r_sample;
                    r_mode    <= M_ADD;
                    r_addr    <= '0;
                    r_rv      <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    // reads issue one slot a cycle, data returns in the cycle after
                    if (r_addr < (AW+1)'(WINDOW_MAX)) begin
                        r_addr <= r_addr + (AW+1)'(1);
                    end
                    r_rv      <= (r_addr < (AW+1)'(WINDOW_MAX));
                    r_ri      <= r_addr[AW-1:0];
                    r_free    <= n_free;
                    r_free_ok <= n_free_ok;
                    case (r_mode)
                        M_REMOVE: begin
                            if (hit || last) begin
                                r_oldest <= oldest_inc;
                                r_fill   <= r_fill - CW'(1);
                                r_state  <= S_EVICT_CHK;
                            end
                        end
                        M_ADD: begin
                            if (hit || last) begin
                                r_state <= S_FINISH;
                            end
                        end
                        default: begin
                            if (cand) begin
                                r_bc  <= cnt_rdata;
                                r_bv  <= val_rdata;
                                r_bok <= 1'b1;
                            end
                            if (last) begin
                                r_state <= S_MUL;
                            end
                        end
                    endcase
                end
                S_FINISH: begin
                    if (r_fill == eff_len) begin
                        r_acc   <= '0;
                        r_taken <= '0;
                        r_pok   <= 1'b0;
                        if (r_top == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_mode  <= M_MAX;
                            r_addr  <= '0;
                            r_rv    <= 1'b0;
                            r_bok   <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    if (!r_bok) begin
                        r_state <= S_DONE;
                    end else begin
                        r_prod  <= prod64[SUM_W-1:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= r_acc + r_prod;
                    r_taken <= r_taken + CFG_W'(1);
                    r_pc    <= r_bc;
                    r_pv    <= r_bv;
                    r_pok   <= 1'b1;
                    if ((r_taken + CFG_W'(1)) == r_top) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr  <= '0;
                        r_rv    <= 1'b0;
                        r_bok   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_sum   <= r_acc;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_window_sum = r_sum;
endmodule

@@ rtl/swtfs_checker.sv @@
// ----------------------------------------------------------------------------
// swtfs_checker
// port level checks of the sliding window top frequency sum block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swtfs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input swtfs_pkg::t_sample   i_sample,
    input logic                 i_start_req,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input swtfs_pkg::t_sum      o_window_sum,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input swtfs_pkg::t_cfg_idx  i_cfg_index,
    input swtfs_pkg::t_cfg      i_cfg_data
);
    import swtfs_pkg::*;

    logic in_txn;
    logic len_wr;

    assign in_txn = i_in_valid && !o_in_stall;
    assign len_wr = i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_WINDOW_LEN);

    // a stalled result holds
    `SWTFS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_window_sum), "result changed under stall")

    // an accepted transaction keeps the block busy
    `SWTFS_ASSERT(a_busy_after_in, i_clk, i_rst_n, in_txn |=> o_in_stall && !o_cfg_ready, "ready right after a transaction")

    // a window length write starts the clearing pass
    `SWTFS_ASSERT(a_clear_after_len, i_clk, i_rst_n, len_wr |=> o_in_stall && !o_cfg_ready, "no clearing pass after window length write")

    // no result can appear in the cycle after a transaction
    `SWTFS_ASSERT(a_no_quick_result, i_clk, i_rst_n, in_txn |=> !$rose(o_out_valid), "result too early")

    // reset drops the output and clears the table before taking items
    `SWTFS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && o_in_stall, "reset not honored")

endmodule

bind sliding_window_top_frequency_sum swtfs_checker u_swtfs_checker (.*);

@@ tb/sv/swtfs_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swtfs_scoreboard
// watches the in, out and cfg channels of the sliding window top frequency
// sum block, predicts every window sum and compares it with the block
// ----------------------------------------------------------------------------
module swtfs_scoreboard (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  swtfs_pkg::t_sample   i_sample,
    input  logic                 i_start_req,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  swtfs_pkg::t_sum      i_window_sum,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  swtfs_pkg::t_cfg_idx  i_cfg_index,
    input  swtfs_pkg::t_cfg      i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results
);
    import swtfs_pkg::*;

    localparam int DEPTH = 256;

    t_cfg    win_reg;
    t_cfg    top_reg;
    t_sample ring[DEPTH];
    t_sample vals[DEPTH];
    int      cnts[DEPTH];
    int      fill;
    int      oldest;
    t_sum    sums_due[$];

    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++) cnts[i] = 0;
        fill   = 0;
        oldest = 0;
    endfunction

    function automatic void tally_add(t_sample v);
        int free_slot;
        free_slot = DEPTH;
        for (int i = 0; i < DEPTH; i++) begin
            if (cnts[i] != 0 && vals[i] == v) begin
                cnts[i]++;
                return;
            end
            if (cnts[i] == 0 && free_slot == DEPTH) free_slot = i;
        end
        if (free_slot < DEPTH) begin
            vals[free_slot] = v;
            cnts[free_slot] = 1;
        end
    endfunction

    function automatic void tally_drop(t_sample v);
        for (int i = 0; i < DEPTH; i++) begin
            if (cnts[i] != 0 && vals[i] == v) begin
                cnts[i]--;
                return;
            end
        end
    endfunction

    function automatic t_sum ranked_sum();
        int     live[$];
        int     rank;
        longint acc;
        acc = 0;
        for (int i = 0; i < DEPTH; i++) if (cnts[i] != 0) live = {live, i};
        foreach (live[a]) begin
            rank = 0;
            foreach (live[b]) begin
                if (a != b && (cnts[live[b]] > cnts[live[a]] ||
                    (cnts[live[b]] == cnts[live[a]] && vals[live[b]] > vals[live[a]])))
                    rank++;
            end
            if (rank < int'(top_reg))
                acc += longint'(cnts[live[a]]) * longint'(vals[live[a]]);
        end
        return t_sum'(acc);
    endfunction

    function automatic void take_sample(t_sample v, logic start);
        int len;
        if (start) clear_window();
        len = (win_reg == 0) ? 1 : (win_reg > DEPTH) ? DEPTH : int'(win_reg);
        while (fill >= len && fill > 0) begin
            tally_drop(ring[oldest]);
            oldest = (oldest + 1) % DEPTH;
            fill--;
        end
        ring[(oldest + fill) % DEPTH] = v;
        fill++;
        tally_add(v);
        if (fill == len) sums_due = {sums_due, ranked_sum()};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg = 1;
            top_reg = 1;
            clear_window();
            sums_due.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sums_due.size() == 0) begin
                    $error("window_sum with no transaction outstanding, got %0d",
                           i_window_sum);
                    o_errors <= o_errors + 1;
                end else begin
                    if (i_window_sum !== sums_due[0]) begin
                        $error("window_sum expected %0d got %0d",
                               sums_due[0], i_window_sum);
                        o_errors <= o_errors + 1;
                    end
                    void'(sums_due.pop_front());
                end
                o_results <= o_results + 1;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WINDOW_LEN) begin
                    win_reg = i_cfg_data;
                    clear_window();
                end else if (i_cfg_index == REG_TOP_COUNT) begin
                    top_reg = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) take_sample(i_sample, i_start_req);
        end
        o_pending <= sums_due.size();
    end

endmodule

@@ tb/sv/tb_sliding_window_top_frequency_sum.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_top_frequency_sum
// drives samples, start requests and register writes with random idling on
// both channels; a checker module predicts and compares every window sum
// ----------------------------------------------------------------------------
module tb_sliding_window_top_frequency_sum;
    import swtfs_pkg::*;

    localparam int WMAX = 256;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_sample  i_sample = '0;
    logic     i_start_req = 1'b0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_sum     o_window_sum;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index = '0;
    t_cfg     i_cfg_data = '0;

    int       errors;
    int       pending;
    int       results;
    int       sent = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       cur_win = 1;
    int       cur_top = 1;
    t_sample  pool[6];

    always #10 i_clk = ~i_clk;

    sliding_window_top_frequency_sum #(.WINDOW_MAX(WMAX)) uut (.*);

    swtfs_scoreboard checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_sample,
        .i_start_req, .i_out_valid(o_out_valid), .i_out_stall,
        .i_window_sum(o_window_sum), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < stall_pct);
    end

    // worst case busy time of one transaction under the current registers
    function automatic int settle_cycles();
        int k;
        k = (cur_top < cur_win) ? cur_top : cur_win;
        if (k > WMAX) k = WMAX;
        return 3 * (WMAX + 1) + WMAX + (WMAX + 3) * k + 64;
    endfunction

    task automatic send(t_sample v, logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample    = v;
        i_start_req = start;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg data);
        while (pending != 0) @(negedge i_clk);
        repeat (settle_cycles()) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == REG_WINDOW_LEN) cur_win = (data == 0) ? 1 : int'(data);
        else if (idx == REG_TOP_COUNT) cur_top = int'(data);
    endtask

    function automatic void set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
        endcase
    endfunction

    // kind 0 full range, 1 small pool with repeats, 2 the two extremes
    function automatic t_sample pick(int kind);
        case (kind)
            0: return t_sample'($urandom);
            1: return pool[$urandom_range(5)];
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    task automatic run_phase(int win, int top, int n, int kind, int mode);
        write_reg(REG_WINDOW_LEN, t_cfg'(win));
        write_reg(REG_TOP_COUNT, t_cfg'(top));
        pool[0] = 32'sh7fffffff;
        pool[1] = 32'sh80000000;
        for (int i = 2; i < 6; i++)
            pool[i] = $urandom_range(1) ? t_sample'($urandom) : t_sample'($urandom_range(8)) - 4;
        set_idling(mode);
        for (int i = 0; i < n; i++)
            send(pick(kind), $urandom_range(99) < 3);
        set_idling(0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // window zero acts as one, extremes pass straight through
        write_reg(REG_WINDOW_LEN, 9'd0);
        send(32'sh7fffffff, 1'b0);
        send(32'sh80000000, 1'b0);
        send(32'sh0, 1'b1);
        send(-32'sd1, 1'b0);
        // index beyond the register list is ignored
        write_reg(t_cfg_idx'(5), 9'h1ff);
        write_reg(REG_TOP_COUNT, 9'd0);
        write_reg(REG_WINDOW_LEN, 9'd3);
        send(32'sd5, 1'b0);
        send(32'sd5, 1'b0);
        send(32'sd7, 1'b0);
        // ties in count rank by value
        write_reg(REG_TOP_COUNT, 9'd1);
        send(-32'sd4, 1'b0);
        send(32'sd4, 1'b0);
        send(32'sd9, 1'b1);
        send(32'sd9, 1'b0);
        send(-32'sd2, 1'b0);
        send(-32'sd2, 1'b0);
        write_reg(REG_TOP_COUNT, 9'h1ff);
        send(32'sd1, 1'b0);
        send(32'sh80000000, 1'b0);
        send(32'sd3, 1'b0);
        write_reg(REG_TOP_COUNT, 9'd2);
        send(32'sh7fffffff, 1'b0);
        send(32'sh7fffffff, 1'b0);
        send(32'sh80000000, 1'b0);

        run_phase(5,   2,   200, 1, 0);
        run_phase(1,   1,   150, 0, 1);
        run_phase(12,  3,   200, 1, 2);
        run_phase(8,   256, 150, 1, 3);
        run_phase(256, 3,   300, 1, 0);
        run_phase(511, 256, 300, 2, 1);
        run_phase(2,   0,   100, 1, 2);
        run_phase(16,  1,   200, 0, 3);

        while (pending != 0) @(negedge i_clk);
        repeat (settle_cycles()) @(negedge i_clk);
        $display("sent %0d samples over window lengths 0..511 and top counts 0..511,",
                 sent);
        $display("checked %0d window sums with idle and stall on both channels", results);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
